/* hdl/frca_pkg.sv */
// shared types and constants of the frame ring column average block
package frca_pkg;

    // fixed field and register widths
    localparam int OP_BITS       = 2;
    localparam int ROW_IDX_BITS  = 8;
    localparam int LEN_BITS      = 9;
    localparam int WIN_BITS      = 7;
    localparam int CFG_DATA_BITS = 9;
    localparam int CFG_ADDR_BITS = 2;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_STORE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_AVG   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_ROW   = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_DATA_LEN   = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_LEN = 2'd1;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_en;
        logic wr_sample;
        logic capture;
        logic col_clear;
        logic col_next;
        logic row_clear;
        logic row_next;
        logic rd_en;
        logic rd_sel_idx;
        logic acc_clear;
        logic acc_take;
        logic div_start;
        logic out_load;
        logic out_sel_avg;
    } frca_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_done;
        logic row_last;
        logic col_last;
        logic div_done;
        logic out_free;
    } frca_sts_t;

endpackage

/* hdl/frame_ring_column_average.sv */
// A store beat (op 0) is written in the cycle it is accepted, one beat per cycle while
// the controller is idle. Column averages (op 1): each column is summed by the
// one-entry-per-cycle memory read walk and divided by the one-bit-per-cycle divider.
// Row readout (op 2): each column passes through the registered memory read.
// Reset: synchronous active-low; then a clearing sweep writes zero to all
// MAX_ROWS * 2**clog2(MAX_COLS) entries (16384 by default) and takes no input beat.
module frame_ring_column_average #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [frca_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [frca_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    // input beats
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata fields from bit 0: sample, row_index, zero fill
    input  logic [((SAMPLE_BITS+8+7)/8)*8-1:0]   s_tdata,
    // s_tuser fields from bit 0: op
    input  logic [frca_pkg::OP_BITS-1:0]         s_tuser,
    // result beats
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata fields from bit 0: value, zero fill
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
    output logic                                 m_tlast
);
    import frca_pkg::*;

    localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    frca_cmd_t                     cmd;
    frca_sts_t                     sts;
    logic signed [SAMPLE_BITS-1:0] out_value;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [ROW_IDX_BITS-1:0]       in_row;

    // unpack input beat
    assign in_sample = s_tdata[SAMPLE_BITS-1:0];
    assign in_row    = s_tdata[SAMPLE_BITS+ROW_IDX_BITS-1:SAMPLE_BITS];

    // sequencing
    frca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // storage and arithmetic
    frca_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .sample    (in_sample),
        .row_index (in_row),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    // pack result beat
    assign m_tdata = OUT_DATA_BITS'($unsigned(out_value));

endmodule

/* hdl/frca_div.sv */
// restoring divider: signed sum by unsigned row count, truncating toward zero
module frca_div #(
    parameter int SUM_BITS = 33,
    parameter int OUT_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [SUM_BITS-1:0]        dividend,
    input  logic [frca_pkg::LEN_BITS-1:0]     divisor,
    output logic                              busy,
    output logic signed [OUT_BITS-1:0]        quotient
);
    import frca_pkg::*;

    localparam int CNT_W = $clog2(SUM_BITS + 1);

    logic [SUM_BITS-1:0] q_reg, q_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                neg_reg, neg_next;
    logic [LEN_BITS:0]   rem_shift;
    logic [LEN_BITS:0]   rem_sub;
    logic                fits;
    logic [SUM_BITS-1:0] magnitude;
    logic [OUT_BITS-1:0] q_low;

    // one quotient bit per cycle
    always_comb begin
        magnitude = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
        rem_shift = {rem_reg, q_reg[SUM_BITS-1]};
        rem_sub   = rem_shift - {1'b0, divisor};
        fits      = (rem_shift >= {1'b0, divisor});
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        if (start) begin
            q_next    = magnitude;
            rem_next  = '0;
            cnt_next  = CNT_W'(SUM_BITS);
            busy_next = 1'b1;
            neg_next  = dividend[SUM_BITS-1];
        end else if (busy_reg) begin
            q_next   = {q_reg[SUM_BITS-2:0], fits};
            rem_next = fits ? rem_sub[LEN_BITS-1:0] : rem_shift[LEN_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // apply sign to the magnitude quotient
    assign q_low    = q_reg[OUT_BITS-1:0];
    assign quotient = neg_reg ? -$signed(q_low) : $signed(q_low);
    assign busy     = busy_reg;

endmodule

/* hdl/frca_datapath.sv */
// datapath: config registers, sample ring memory, counters, accumulator, divider, output register
module frca_datapath #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [frca_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [frca_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic [frca_pkg::ROW_IDX_BITS-1:0]    row_index,
    input  frca_pkg::frca_cmd_t                  cmd,
    output frca_pkg::frca_sts_t                  sts,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [SAMPLE_BITS-1:0]        out_value,
    output logic                                 out_last
);
    import frca_pkg::*;

    localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int CNT_BITS  = (ROW_BITS + 1 > LEN_BITS) ? ROW_BITS + 1 : LEN_BITS;
    localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
    localparam int MEM_DEPTH = MAX_ROWS * (1 << COL_BITS);
    localparam int ADDR_BITS = $clog2(MEM_DEPTH);
    localparam logic [LEN_BITS-1:0] ROWS_CAP = (MAX_ROWS > 511) ? 9'd511 : LEN_BITS'(MAX_ROWS);
    localparam logic [LEN_BITS-1:0] DL_RESET = (MAX_ROWS < 256) ? LEN_BITS'(MAX_ROWS) : 9'd256;
    localparam logic [WIN_BITS-1:0] COLS_CAP = WIN_BITS'(MAX_COLS);

    logic [LEN_BITS-1:0]          data_len_reg, data_len_next;
    logic [WIN_BITS-1:0]          window_len_reg, window_len_next;
    logic [CNT_BITS-1:0]          wr_row_reg, wr_row_next;
    logic [COL_BITS-1:0]          wr_col_reg, wr_col_next;
    logic [ADDR_BITS-1:0]         clr_addr_reg;
    logic [CNT_BITS-1:0]          rd_row_reg;
    logic [COL_BITS-1:0]          col_reg;
    logic [ROW_BITS-1:0]          row_idx_reg;
    logic                         row_oob_reg;
    logic                         rd_acc_reg;
    logic signed [SUM_BITS-1:0]   acc_reg;
    logic                         out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_value_reg;
    logic                         out_last_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] mem [MEM_DEPTH];

    logic [LEN_BITS-1:0]          dl_wr;
    logic [WIN_BITS-1:0]          wl_wr;
    logic [CNT_BITS-1:0]          wr_row_inc;
    logic [WIN_BITS-1:0]          wr_col_inc;
    logic                         mem_we;
    logic [ADDR_BITS-1:0]         mem_waddr;
    logic signed [SAMPLE_BITS-1:0] mem_wdata;
    logic [ROW_BITS-1:0]          rd_row_sel;
    logic [ADDR_BITS-1:0]         rd_addr;
    logic                         div_busy;
    logic signed [SAMPLE_BITS-1:0] div_q;
    logic [WIN_BITS-1:0]          col_ext;

    // saturate incoming register values
    always_comb begin
        dl_wr = cfg_wdata[LEN_BITS-1:0];
        if (dl_wr == '0) begin
            dl_wr = LEN_BITS'(1);
        end else if (dl_wr > ROWS_CAP) begin
            dl_wr = ROWS_CAP;
        end
        wl_wr = cfg_wdata[WIN_BITS-1:0];
        if (wl_wr < WIN_BITS'(2)) begin
            wl_wr = WIN_BITS'(2);
        end else if (wl_wr > COLS_CAP) begin
            wl_wr = COLS_CAP;
        end
    end

    // config registers and ring write position
    always_comb begin
        data_len_next   = data_len_reg;
        window_len_next = window_len_reg;
        wr_row_next     = wr_row_reg;
        wr_col_next     = wr_col_reg;
        wr_row_inc      = wr_row_reg + 1'b1;
        wr_col_inc      = {{(WIN_BITS-COL_BITS){1'b0}}, wr_col_reg} + 1'b1;
        if (cmd.wr_sample) begin
            if (wr_row_inc >= CNT_BITS'(data_len_reg)) begin
                wr_row_next = '0;
                wr_col_next = (wr_col_inc >= window_len_reg) ? '0 : COL_BITS'(wr_col_inc);
            end else begin
                wr_row_next = wr_row_inc;
            end
        end
        if (cfg_wr_en && (cfg_addr == REG_DATA_LEN || cfg_addr == REG_WINDOW_LEN)) begin
            wr_row_next = '0;
            wr_col_next = '0;
            if (cfg_addr == REG_DATA_LEN) begin
                data_len_next = dl_wr;
            end else begin
                window_len_next = wl_wr;
            end
        end
    end

    // control state of the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_len_reg   <= DL_RESET;
            window_len_reg <= COLS_CAP;
            wr_row_reg     <= '0;
            wr_col_reg     <= '0;
            clr_addr_reg   <= '0;
            rd_row_reg     <= '0;
            col_reg        <= '0;
            rd_acc_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            data_len_reg   <= data_len_next;
            window_len_reg <= window_len_next;
            wr_row_reg     <= wr_row_next;
            wr_col_reg     <= wr_col_next;
            rd_acc_reg     <= cmd.acc_take;
            if (cmd.clr_en) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.row_clear) begin
                rd_row_reg <= '0;
            end else if (cmd.row_next) begin
                rd_row_reg <= rd_row_reg + 1'b1;
            end
            if (cmd.col_clear) begin
                col_reg <= '0;
            end else if (cmd.col_next) begin
                col_reg <= col_reg + 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // memory write and read address selection
    always_comb begin
        mem_we     = cmd.clr_en || cmd.wr_sample;
        mem_waddr  = cmd.clr_en ? clr_addr_reg
                                : ADDR_BITS'({wr_row_reg[ROW_BITS-1:0], wr_col_reg});
        mem_wdata  = cmd.clr_en ? '0 : sample;
        rd_row_sel = cmd.rd_sel_idx ? row_idx_reg : rd_row_reg[ROW_BITS-1:0];
        rd_addr    = ADDR_BITS'({rd_row_sel, col_reg});
    end

    // sample ring memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // row select capture, accumulator and output payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            row_idx_reg <= ROW_BITS'(row_index);
            row_oob_reg <= ({{(32-ROW_IDX_BITS){1'b0}}, row_index} >= 32'(MAX_ROWS));
        end
        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (rd_acc_reg) begin
            acc_reg <= acc_reg + {{(SUM_BITS-SAMPLE_BITS){rd_data_reg[SAMPLE_BITS-1]}},
                                  rd_data_reg};
        end
        if (cmd.out_load) begin
            out_value_reg <= cmd.out_sel_avg ? div_q : (row_oob_reg ? '0 : rd_data_reg);
            out_last_reg  <= sts.col_last;
        end
    end

    // column average divider
    frca_div #(
        .SUM_BITS (SUM_BITS),
        .OUT_BITS (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (data_len_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // status to the controller
    assign col_ext      = {{(WIN_BITS-COL_BITS){1'b0}}, col_reg};
    assign sts.clr_done = (clr_addr_reg == ADDR_BITS'(MEM_DEPTH - 1));
    assign sts.row_last = ((rd_row_reg + 1'b1) == CNT_BITS'(data_len_reg));
    assign sts.col_last = ((col_ext + 1'b1) == window_len_reg);
    assign sts.div_done = !div_busy;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

/* hdl/frca_ctrl.sv */
// controller: sequences clearing, sample writes, column averages and row readouts
module frca_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  logic [frca_pkg::OP_BITS-1:0]    in_op,
    output logic                            in_ready,
    output frca_pkg::frca_cmd_t             cmd,
    input  frca_pkg::frca_sts_t             sts
);
    import frca_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_SUM_RD   = 9'b000000100,
        ST_SUM_WAIT = 9'b000001000,
        ST_DIV_GO   = 9'b000010000,
        ST_DIV      = 9'b000100000,
        ST_AVG_OUT  = 9'b001000000,
        ST_ROW_RD   = 9'b010000000,
        ST_ROW_OUT  = 9'b100000000
    } frca_state_t;

    frca_state_t state_reg, state_next;
    logic        accept;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        accept     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                accept   = in_valid;
                if (accept) begin
                    priority if (in_op == OP_STORE) begin
                        cmd.wr_sample = 1'b1;
                    end else if (in_op == OP_AVG) begin
                        cmd.col_clear = 1'b1;
                        cmd.row_clear = 1'b1;
                        cmd.acc_clear = 1'b1;
                        state_next    = ST_SUM_RD;
                    end else if (in_op == OP_ROW) begin
                        cmd.col_clear = 1'b1;
                        cmd.capture   = 1'b1;
                        state_next    = ST_ROW_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SUM_RD: begin
                cmd.rd_en    = 1'b1;
                cmd.acc_take = 1'b1;
                cmd.row_next = 1'b1;
                if (sts.row_last) begin
                    state_next = ST_SUM_WAIT;
                end
            end
            ST_SUM_WAIT: begin
                cmd.row_clear = 1'b1;
                state_next    = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_AVG_OUT;
                end
            end
            ST_AVG_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_sel_avg = 1'b1;
                    if (sts.col_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.col_next  = 1'b1;
                        cmd.acc_clear = 1'b1;
                        state_next    = ST_SUM_RD;
                    end
                end
            end
            ST_ROW_RD: begin
                cmd.rd_en      = 1'b1;
                cmd.rd_sel_idx = 1'b1;
                state_next     = ST_ROW_OUT;
            end
            ST_ROW_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.col_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.col_next = 1'b1;
                        state_next   = ST_ROW_RD;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // output register must be free when a result is loaded
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken result");

    // divider is restarted only when idle
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> sts.div_done)
        else $error("divider restarted while busy");

    // clearing sweep and sample writes share the write port
    a_wr_port: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_sample |-> !cmd.clr_en)
        else $error("sample write during clearing sweep");

    // a divide always follows the last row read of a column
    a_sum_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM_WAIT) |=> cmd.div_start)
        else $error("divider not started after column sum");

endmodule
